// ----- hw/rtl/linear_probe_hash_map_top_defines.svh -----
// Assertion macros used by the hash map probe sequencer.
`ifndef LINEAR_PROBE_HASH_MAP_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LPHM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LPHM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error(msg);

`endif

// ----- hw/rtl/lphm_pkg.sv -----
// Shared constants, codes and types for the linear probe hash map.
package lphm_pkg;

   // table geometry
   localparam int SLOTS  = 1024;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int NUM_W  = SLOT_W + 1;

   // item field widths
   localparam int KEY_W       = 32;
   localparam int HANDLE_W    = 32;
   localparam int SLOT_OUT_W  = 10;
   localparam int COUNT_OUT_W = 11;
   localparam int CFG_W       = 11;
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

   // register map: index of each register, byte address is four times the index
   localparam logic REG_SLOTS_IN_USE = 1'b0;

   // memory entry: {occupied, key, handle}
   localparam int ENTRY_W = 1 + KEY_W + HANDLE_W;

   // remainder unit: key bits consumed per cycle
   localparam int MOD_DIGIT = 8;
   localparam int MOD_STEPS = KEY_W / MOD_DIGIT;
   localparam int MOD_CNT_W = $clog2(MOD_STEPS);

   // stream widths
   localparam int REQ_DATA_W = KEY_W + HANDLE_W;
   localparam int REQ_USER_W = 1;
   localparam int RSP_USED_W = HANDLE_W + SLOT_OUT_W + COUNT_OUT_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;
   localparam int RSP_USER_W = 3;

   // commands
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // result status codes
   typedef enum logic [RSP_USER_W-1:0] {
      STAT_NEW       = 3'd0,
      STAT_REPLACED  = 3'd1,
      STAT_FOUND     = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_FULL      = 3'd4
   } status_type;

   // control into the remainder unit
   typedef struct packed {
      logic             start;
      logic             advance;
      logic [KEY_W-1:0] key;
   } mod_ctl_type;

   // status out of the remainder unit
   typedef struct packed {
      logic              last;
      logic [SLOT_W-1:0] rem_next;
   } mod_stat_type;

endpackage

// ----- hw/rtl/lphm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lphm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/lphm_mod.sv -----
// Key modulo slot count: restoring remainder, MOD_DIGIT key bits per cycle while advance is high.
module lphm_mod (
   input  logic                         clock,
   input  lphm_pkg::mod_ctl_type        mod_ctl,
   input  logic [lphm_pkg::NUM_W-1:0]   divisor,
   output lphm_pkg::mod_stat_type       mod_stat
);

   logic [lphm_pkg::KEY_W-1:0]     key_sh_ff, key_sh_in;
   logic [lphm_pkg::SLOT_W-1:0]    rem_ff, rem_in, rem_next;
   logic [lphm_pkg::MOD_CNT_W-1:0] cnt_ff, cnt_in;

   // one digit of remainder steps, MSB first
   always_comb begin
      logic [lphm_pkg::NUM_W-1:0] acc;
      acc = {1'b0, rem_ff};
      for (int i = 0; i < lphm_pkg::MOD_DIGIT; i++) begin
         acc = {acc[lphm_pkg::NUM_W-2:0], key_sh_ff[lphm_pkg::KEY_W-1-i]};
         if (acc >= divisor) begin
            acc = acc - divisor;
         end
      end
      rem_next = acc[lphm_pkg::SLOT_W-1:0];
   end

   // load on start, shift a digit per advance
   always_comb begin
      key_sh_in = key_sh_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      if (mod_ctl.start) begin
         key_sh_in = mod_ctl.key;
         rem_in    = '0;
         cnt_in    = '0;
      end else if (mod_ctl.advance) begin
         key_sh_in = key_sh_ff << lphm_pkg::MOD_DIGIT;
         rem_in    = rem_next;
         cnt_in    = cnt_ff + lphm_pkg::MOD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      key_sh_ff <= key_sh_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
   end

   assign mod_stat.last     = (cnt_ff == lphm_pkg::MOD_CNT_W'(lphm_pkg::MOD_STEPS - 1));
   assign mod_stat.rem_next = rem_next;

endmodule

// ----- hw/rtl/lphm_probe.sv -----
// Probe sequencer: clearing pass, home slot, linear walk over the slot RAM.
`include "linear_probe_hash_map_top_defines.svh"

module lphm_probe (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lphm_pkg::NUM_W-1:0]        n_eff,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lphm_pkg::REQ_DATA_W-1:0]   req_tdata,   // key, handle_in
   input  logic [lphm_pkg::REQ_USER_W-1:0]   req_tuser,   // cmd
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lphm_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // handle_out, slot, entry_count
   output logic [lphm_pkg::RSP_USER_W-1:0]   rsp_tuser    // status
);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_MOD   = 4'b0100,
      S_CHECK = 4'b1000
   } state_type;

   state_type                        state_ff, state_in;
   logic [lphm_pkg::SLOT_W-1:0]      clr_ff, clr_in;
   logic [lphm_pkg::SLOT_W-1:0]      idx_ff, idx_in;
   logic [lphm_pkg::NUM_W-1:0]       step_ff, step_in;
   logic [lphm_pkg::NUM_W-1:0]       pair_ff, pair_in;
   logic                             cmd_ff, cmd_in;
   logic [lphm_pkg::KEY_W-1:0]       key_ff, key_in;
   logic [lphm_pkg::HANDLE_W-1:0]    handle_ff, handle_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   lphm_pkg::status_type             rsp_status_ff, status_in;
   logic [lphm_pkg::HANDLE_W-1:0]    rsp_handle_ff, hout_in;
   logic [lphm_pkg::SLOT_OUT_W-1:0]  rsp_slot_ff, slot_in;
   logic [lphm_pkg::COUNT_OUT_W-1:0] rsp_count_ff;

   logic                             mem_we;
   logic [lphm_pkg::SLOT_W-1:0]      mem_waddr, mem_raddr;
   logic [lphm_pkg::ENTRY_W-1:0]     mem_wdata, rd_entry;
   logic                             rd_occ;
   logic [lphm_pkg::KEY_W-1:0]       rd_key;
   logic [lphm_pkg::HANDLE_W-1:0]    rd_handle;

   lphm_pkg::mod_ctl_type            mod_ctl;
   lphm_pkg::mod_stat_type           mod_stat;

   logic                             req_fire;
   logic [lphm_pkg::NUM_W-1:0]       idx_inc;
   logic [lphm_pkg::SLOT_W-1:0]      idx_wrap;
   logic                             last_step, probe_hit, resolve, out_free, finish;

   // slot memory
   lphm_ram #(
      .WIDTH (lphm_pkg::ENTRY_W),
      .DEPTH (lphm_pkg::SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (rd_entry)
   );

   lphm_mod u_mod (
      .clock    (clock),
      .mod_ctl  (mod_ctl),
      .divisor  (n_eff),
      .mod_stat (mod_stat)
   );

   assign rd_occ    = rd_entry[lphm_pkg::ENTRY_W-1];
   assign rd_key    = rd_entry[lphm_pkg::KEY_W+lphm_pkg::HANDLE_W-1:lphm_pkg::HANDLE_W];
   assign rd_handle = rd_entry[lphm_pkg::HANDLE_W-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // probe decisions for the slot whose data is on the RAM output
   assign idx_inc   = {1'b0, idx_ff} + lphm_pkg::NUM_W'(1);
   assign idx_wrap  = (idx_inc == n_eff) ? '0 : idx_inc[lphm_pkg::SLOT_W-1:0];
   assign last_step = ((step_ff + lphm_pkg::NUM_W'(1)) == n_eff);
   assign probe_hit = !rd_occ || (rd_key == key_ff);
   assign resolve   = (state_ff == S_CHECK) && (probe_hit || last_step);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign finish    = resolve && out_free;

   // result of the resolved probe
   always_comb begin
      status_in = lphm_pkg::STAT_NOT_FOUND;
      hout_in   = '0;
      slot_in   = '0;
      pair_in   = pair_ff;
      if (cmd_ff == lphm_pkg::CMD_INSERT) begin
         if (!probe_hit) begin
            status_in = lphm_pkg::STAT_FULL;
         end else if (rd_occ) begin
            status_in = lphm_pkg::STAT_REPLACED;
            slot_in   = lphm_pkg::SLOT_OUT_W'(idx_ff);
         end else begin
            status_in = lphm_pkg::STAT_NEW;
            slot_in   = lphm_pkg::SLOT_OUT_W'(idx_ff);
            if (finish) begin
               pair_in = pair_ff + lphm_pkg::NUM_W'(1);
            end
         end
      end else begin
         if (probe_hit && rd_occ) begin
            status_in = lphm_pkg::STAT_FOUND;
            hout_in   = rd_handle;
            slot_in   = lphm_pkg::SLOT_OUT_W'(idx_ff);
         end
      end
   end

   // memory write: clearing pass or insert/update
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = {1'b1, key_ff, handle_ff};
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (finish && (cmd_ff == lphm_pkg::CMD_INSERT) && probe_hit) begin
         mem_we = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      idx_in          = idx_ff;
      step_in         = step_ff;
      cmd_in          = cmd_ff;
      key_in          = key_ff;
      handle_in       = handle_ff;
      mem_raddr       = idx_ff;
      mod_ctl.start   = 1'b0;
      mod_ctl.advance = 1'b0;
      mod_ctl.key     = req_tdata[lphm_pkg::KEY_W-1:0];
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + lphm_pkg::SLOT_W'(1);
            if (clr_ff == lphm_pkg::SLOT_W'(lphm_pkg::SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in        = req_tuser[0];
               key_in        = req_tdata[lphm_pkg::KEY_W-1:0];
               handle_in     = req_tdata[lphm_pkg::REQ_DATA_W-1:lphm_pkg::KEY_W];
               mod_ctl.start = 1'b1;
               state_in      = S_MOD;
            end
         end
         S_MOD: begin
            mod_ctl.advance = 1'b1;
            if (mod_stat.last) begin
               // issue the home slot read straight from the remainder
               idx_in    = mod_stat.rem_next;
               step_in   = '0;
               mem_raddr = mod_stat.rem_next;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            if (finish) begin
               state_in = S_IDLE;
            end else if (!resolve) begin
               // next slot, read issued this cycle
               idx_in    = idx_wrap;
               step_in   = step_ff + lphm_pkg::NUM_W'(1);
               mem_raddr = idx_wrap;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pair_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pair_ff      <= pair_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      step_ff   <= step_in;
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      handle_ff <= handle_in;
      if (finish) begin
         rsp_status_ff <= status_in;
         rsp_handle_ff <= hout_in;
         rsp_slot_ff   <= slot_in;
         rsp_count_ff  <= lphm_pkg::COUNT_OUT_W'(pair_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{lphm_pkg::RSP_PAD_W{1'b0}}, rsp_count_ff, rsp_slot_ff, rsp_handle_ff};

   `LPHM_ASSERT_IMP(a_mem_we_state, clock, reset, mem_we,
      (state_ff == S_CLEAR) || (state_ff == S_CHECK), "slot RAM written outside clear or check")
   `LPHM_ASSERT_IMP(a_step_bound, clock, reset, state_ff == S_CHECK,
      (step_ff < n_eff) && ({1'b0, idx_ff} < n_eff), "probe walked past the slots in use")
   `LPHM_ASSERT_NEXT(a_pair_hold, clock, reset, !(finish && (cmd_ff == lphm_pkg::CMD_INSERT)),
      $stable(pair_ff), "entry count changed without an insert")
   `LPHM_ASSERT_IMP(a_pair_bound, clock, reset, 1'b1,
      pair_ff <= lphm_pkg::NUM_W'(lphm_pkg::SLOTS), "entry count above slot count")

endmodule

// ----- hw/rtl/linear_probe_hash_map_top.sv -----
// Linear probe hash map: 32-bit key to 32-bit handle, open addressing, linear probing.
// Each item runs the home slot remainder, then probes P slots (1 to slots in use) for its result.
// Items are taken one at a time: req_tready is high only while idle. The remainder is computed 8 key bits
// a cycle, then the slot RAM is read once per cycle of the probe walk.
// Reset: synchronous; after release a pass over all 1024 slots clears the slot RAM, req_tready stays
// low meanwhile; slots_in_use returns to 1024 and the entry count to zero.
module linear_probe_hash_map_top (
   input  logic                              clock,
   input  logic                              reset,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [2:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lphm_pkg::REQ_DATA_W-1:0]   req_tdata,   // [31:0] key, [63:32] handle_in
   input  logic [lphm_pkg::REQ_USER_W-1:0]   req_tuser,   // [0] cmd
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lphm_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [31:0] handle_out, [41:32] slot,
                                                          // [52:42] entry_count, rest zero
   output logic [lphm_pkg::RSP_USER_W-1:0]   rsp_tuser    // [2:0] status
);

   logic [lphm_pkg::CFG_W-1:0] slots_ff, slots_in;
   logic [lphm_pkg::NUM_W-1:0] n_eff;
   logic                       csr_wr, csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == lphm_pkg::REG_SLOTS_IN_USE);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;

   // register write
   always_comb begin
      slots_in = slots_ff;
      if (csr_wr) begin
         slots_in = csr_pwdata[lphm_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= lphm_pkg::CFG_RESET;
      end else begin
         slots_ff <= slots_in;
      end
   end

   // register read
   assign csr_prdata = csr_hit ? {{(32 - lphm_pkg::CFG_W){1'b0}}, slots_ff} : '0;

   // effective slot count: zero reads as one, saturate at table size
   always_comb begin
      if (slots_ff == '0) begin
         n_eff = lphm_pkg::NUM_W'(1);
      end else if (slots_ff > lphm_pkg::CFG_W'(lphm_pkg::SLOTS)) begin
         n_eff = lphm_pkg::NUM_W'(lphm_pkg::SLOTS);
      end else begin
         n_eff = lphm_pkg::NUM_W'(slots_ff);
      end
   end

   lphm_probe u_probe (
      .clock      (clock),
      .reset      (reset),
      .n_eff      (n_eff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
